// File: design/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants for the sorted key list
// Transaction payload structs, request and status codes, controller state
// and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package skl_pkg;

	// Field widths fixed by the transaction format
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 32;
	localparam int ORIGIN_W = 16;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;

	// Default number of list cells
	localparam int CAPACITY_DEF = 16;

	// Insert limit register
	localparam int               LIMIT_W         = 5;
	localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_kind_t;

	// Input transaction
	typedef struct packed {
		logic [REQ_W-1:0]           req_type;
		logic signed [KEY_W-1:0]    sort_key;
		logic [HANDLE_W-1:0]        item_handle;
		logic [ORIGIN_W-1:0]        source_index;
		logic [SLOT_W-1:0]          read_slot;
	} req_t;

	// Output transaction
	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic [COUNT_W-1:0]         stored_count;
		logic signed [KEY_W-1:0]    read_key;
		logic [HANDLE_W-1:0]        read_handle;
		logic [ORIGIN_W-1:0]        read_source_index;
	} rsp_t;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;   // capture the accepted request
		logic exec;       // update cells and count, load the result register
	} ctrl_cmd_t;

endpackage

// File: design/skl_ctrl.sv
// ----------------------------------------------------------------------------
// skl_ctrl: sequencing for the sorted key list
// Accepts a request, then executes it once the result register is free,
// and tracks the valid flag of the result register.
// ----------------------------------------------------------------------------
module skl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output skl_pkg::ctrl_cmd_t cmd
);

	skl_pkg::ctrl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 res_free;

	// Result register can take a new result
	assign res_free = !out_valid_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			skl_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid) begin
					state_d = skl_pkg::S_EXEC;
				end
			end
			skl_pkg::S_EXEC: begin
				cmd.exec = res_free;
				if (res_free) begin
					state_d = skl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skl_pkg::S_IDLE;
			end
		endcase
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// A result appears only from an executed request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result valid without an executed request");

	// An accepted transaction moves on to the execute state
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> state_q == skl_pkg::S_EXEC)
		else $error("accepted transaction not moved to execute");

	// Execution never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");
`endif

endmodule

// File: design/skl_datapath.sv
// ----------------------------------------------------------------------------
// skl_datapath: register cells, count and result register
// All cells compare against the held request in parallel; an insert or a
// remove shifts the cells by one place.
// ----------------------------------------------------------------------------
module skl_datapath #(
	parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skl_pkg::ctrl_cmd_t            cmd,
	input  logic                          cfg_we,
	input  logic [skl_pkg::LIMIT_W-1:0]   cfg_data,
	input  skl_pkg::req_t                 in_data,
	output skl_pkg::rsp_t                 rsp
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int LCMP_W = (CNT_W > skl_pkg::LIMIT_W) ? CNT_W : skl_pkg::LIMIT_W;
	localparam int SCMP_W = (CNT_W > skl_pkg::SLOT_W) ? CNT_W : skl_pkg::SLOT_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// Held request and state
	skl_pkg::req_t                      req_q;
	logic [skl_pkg::LIMIT_W-1:0]        max_entries_q;
	logic [CNT_W-1:0]                   count_q, count_d;
	logic signed [skl_pkg::KEY_W-1:0]   key_q    [CAPACITY];
	logic [skl_pkg::HANDLE_W-1:0]       handle_q [CAPACITY];
	logic [skl_pkg::ORIGIN_W-1:0]       origin_q [CAPACITY];
	skl_pkg::rsp_t                      rsp_q, rsp_d;

	// Per-cell compare results and shifted contents
	logic [CAPACITY-1:0]                valid, key_gt, match, hit_upto;
	logic signed [skl_pkg::KEY_W-1:0]   ins_key    [CAPACITY];
	logic [skl_pkg::HANDLE_W-1:0]       ins_handle [CAPACITY];
	logic [skl_pkg::ORIGIN_W-1:0]       ins_origin [CAPACITY];
	logic signed [skl_pkg::KEY_W-1:0]   rem_key    [CAPACITY];
	logic [skl_pkg::HANDLE_W-1:0]       rem_handle [CAPACITY];
	logic [skl_pkg::ORIGIN_W-1:0]       rem_origin [CAPACITY];

	logic             full, found, rd_ok, do_ins, do_rem;
	logic [IDX_W-1:0] rd_idx;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
	end

	// Insert limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= skl_pkg::MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_entries_q <= cfg_data;
		end
	end

	// Cell compares and shift networks
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			localparam logic [CAPACITY-1:0] UPTO_MASK =
				{CAPACITY{1'b1}} >> (CAPACITY - 1 - g);

			assign valid[g]    = CNT_W'(g) < count_q;
			assign key_gt[g]   = valid[g] && (req_q.sort_key > key_q[g]);
			assign match[g]    = valid[g] && (handle_q[g] == req_q.item_handle);
			assign hit_upto[g] = |(match & UPTO_MASK);

			// Insert: keep smaller keys, new entry at the boundary, rest move right
			if (g == 0) begin : g_ins_first
				assign ins_key[g]    = key_gt[g] ? key_q[g]    : req_q.sort_key;
				assign ins_handle[g] = key_gt[g] ? handle_q[g] : req_q.item_handle;
				assign ins_origin[g] = key_gt[g] ? origin_q[g] : req_q.source_index;
			end else begin : g_ins_rest
				assign ins_key[g]    = key_gt[g] ? key_q[g] :
					(key_gt[g-1] ? req_q.sort_key : key_q[g-1]);
				assign ins_handle[g] = key_gt[g] ? handle_q[g] :
					(key_gt[g-1] ? req_q.item_handle : handle_q[g-1]);
				assign ins_origin[g] = key_gt[g] ? origin_q[g] :
					(key_gt[g-1] ? req_q.source_index : origin_q[g-1]);
			end

			// Remove: cells at and after the first match move left
			if (g == CAPACITY - 1) begin : g_rem_last
				assign rem_key[g]    = key_q[g];
				assign rem_handle[g] = handle_q[g];
				assign rem_origin[g] = origin_q[g];
			end else begin : g_rem_rest
				assign rem_key[g]    = hit_upto[g] ? key_q[g+1]    : key_q[g];
				assign rem_handle[g] = hit_upto[g] ? handle_q[g+1] : handle_q[g];
				assign rem_origin[g] = hit_upto[g] ? origin_q[g+1] : origin_q[g];
			end
		end
	endgenerate

	// Request decode
	always_comb begin
		full   = (count_q == CAP_CNT) ||
			(LCMP_W'(count_q) >= LCMP_W'(max_entries_q));
		found  = |match;
		rd_ok  = SCMP_W'(req_q.read_slot) < SCMP_W'(count_q);
		rd_idx = IDX_W'(req_q.read_slot);
		do_ins = 1'b0;
		do_rem = 1'b0;

		rsp_d                   = '0;
		rsp_d.status            = skl_pkg::ST_OK;
		count_d                 = count_q;
		unique case (skl_pkg::req_kind_t'(req_q.req_type))
			skl_pkg::REQ_INSERT: begin
				if (full) begin
					rsp_d.status = skl_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			skl_pkg::REQ_REMOVE: begin
				if (found) begin
					do_rem  = 1'b1;
					count_d = count_q - 1'b1;
				end else begin
					rsp_d.status = skl_pkg::ST_NOT_FOUND;
				end
			end
			skl_pkg::REQ_READ: begin
				if (rd_ok) begin
					rsp_d.read_key          = key_q[rd_idx];
					rsp_d.read_handle       = handle_q[rd_idx];
					rsp_d.read_source_index = origin_q[rd_idx];
				end else begin
					rsp_d.status = skl_pkg::ST_EMPTY;
				end
			end
			skl_pkg::REQ_NONE: begin
				rsp_d.status = skl_pkg::ST_OK;
			end
			default: begin
				rsp_d.status = skl_pkg::ST_OK;
			end
		endcase
		rsp_d.stored_count = skl_pkg::COUNT_W'(count_d);
	end

	// Cell storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.exec && do_ins) begin
				key_q[i]    <= ins_key[i];
				handle_q[i] <= ins_handle[i];
				origin_q[i] <= ins_origin[i];
			end else if (cmd.exec && do_rem) begin
				key_q[i]    <= rem_key[i];
				handle_q[i] <= rem_handle[i];
				origin_q[i] <= rem_origin[i];
			end
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTH
	// Count stays within the cell array
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	// A successful insert grows the list by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_ins) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	// Reported count matches the held count
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_q.stored_count == skl_pkg::COUNT_W'(count_q))
		else $error("reported count differs from held count");

	// Held entries stay in ascending key order
	generate
		for (g = 0; g < CAPACITY - 1; g++) begin : g_order_chk
			assert property (@(posedge clk) disable iff (!arst_n)
				(CNT_W'(g + 1) < count_q) |-> (key_q[g] <= key_q[g+1]))
				else $error("cells out of key order");
		end
	endgenerate
`endif

endmodule

// File: design/sorted_key_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_key_list_insert_remove: sorted key list with insert, remove, read
// Holds up to CAPACITY entries (signed 16.16 key, handle, source index)
// sorted ascending by key; a read returns the entry at a slot.
// ----------------------------------------------------------------------------
// Every transaction is accepted in the idle state and then executed in
// the execute state, where all cells compare against the request in
// parallel and shift by one place; the result is then held in an output
// register. A new transaction is taken while a result still waits, and
// execution waits only while that register is still full. Inserts go in
// front of the first key not smaller than the new one (equal keys newest
// first); removes delete the first entry with a matching handle. The insert
// limit written on cfg_we/cfg_data takes effect above CAPACITY as CAPACITY.
// There is no clearing pass after reset; the list starts empty.
module sorted_key_list_insert_remove #(
	parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  skl_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output skl_pkg::rsp_t               out_data,
	input  logic                        cfg_we,
	input  logic [skl_pkg::LIMIT_W-1:0] cfg_data
);

	skl_pkg::ctrl_cmd_t cmd;

	// Sequencing
	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Cells, count and result register
	skl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.rsp      (out_data)
	);

endmodule

// File: sim/sorted_key_list_insert_remove_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_list_insert_remove_tb: self-checking bench for the sorted key list
// Walks a short table of directed requests (empty list, extreme keys, equal
// keys, duplicate handles, full and lowered limits, unused request code), then
// runs phases of biased random traffic under several insert limits. Every
// result is checked field by field against a behavioral list predictor, with
// random idle cycles on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module sorted_key_list_insert_remove_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP          = skl_pkg::CAPACITY_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int WATCHDOG_NS  = 200_000;
	localparam int SETTLE_CYC   = 4;

	// One directed row: optional limit write, the request, optional typed result
	typedef struct {
		bit                          wr_limit;
		logic [skl_pkg::LIMIT_W-1:0] limit;
		skl_pkg::req_t               rq;
		bit                          typed;
		skl_pkg::rsp_t               want;
	} dir_row_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	skl_pkg::req_t               in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	skl_pkg::rsp_t               out_data;
	logic                        cfg_we    = 1'b0;
	logic [skl_pkg::LIMIT_W-1:0] cfg_data  = '0;

	// Predictor state: the list as the block should hold it
	logic signed [skl_pkg::KEY_W-1:0] list_key [CAP];
	logic [skl_pkg::HANDLE_W-1:0]     list_handle [CAP];
	logic [skl_pkg::ORIGIN_W-1:0]     list_origin [CAP];
	int                               list_count = 0;
	int                               list_limit = int'(skl_pkg::MAX_ENTRIES_RST);

	skl_pkg::rsp_t queued_responses [$];
	dir_row_t      stim_table [$];
	skl_pkg::rsp_t want_rsp;
	int unsigned   mismatches = 0;
	bit            steady_flow = 1'b0;

	// Per phase: insert limit (32 = draw one), insert and remove share, no idling
	int ph_limit  [PHASES] = '{16, 31, 3, 0, 1, 16, 32, 31};
	int ph_ins    [PHASES] = '{70, 60, 30, 40, 45, 50, 45, 35};
	int ph_rem    [PHASES] = '{15, 20, 40, 40, 35, 30, 35, 45};
	bit ph_steady [PHASES] = '{0, 1, 0, 0, 1, 0, 1, 0};

	sorted_key_list_insert_remove u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one request to the predicted list and returns its result
	function automatic skl_pkg::rsp_t predict_list_result(input skl_pkg::req_t rq);
		skl_pkg::rsp_t o;
		int            lim;
		int            pos;
		int            j;
		o   = '0;
		lim = (list_limit > CAP) ? CAP : list_limit;
		o.status = skl_pkg::ST_OK;
		case (skl_pkg::req_kind_t'(rq.req_type))
			skl_pkg::REQ_INSERT: begin
				if (list_count >= lim) begin
					o.status = skl_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < list_count && $signed(rq.sort_key) > $signed(list_key[pos]))
						pos++;
					for (j = list_count; j > pos; j--) begin
						list_key[j]    = list_key[j-1];
						list_handle[j] = list_handle[j-1];
						list_origin[j] = list_origin[j-1];
					end
					list_key[pos]    = rq.sort_key;
					list_handle[pos] = rq.item_handle;
					list_origin[pos] = rq.source_index;
					list_count++;
				end
			end
			skl_pkg::REQ_REMOVE: begin
				pos = 0;
				while (pos < list_count && list_handle[pos] != rq.item_handle)
					pos++;
				if (pos >= list_count) begin
					o.status = skl_pkg::ST_NOT_FOUND;
				end else begin
					for (j = pos; j + 1 < list_count; j++) begin
						list_key[j]    = list_key[j+1];
						list_handle[j] = list_handle[j+1];
						list_origin[j] = list_origin[j+1];
					end
					list_count--;
				end
			end
			skl_pkg::REQ_READ: begin
				if (int'(rq.read_slot) < list_count) begin
					o.read_key          = list_key[rq.read_slot];
					o.read_handle       = list_handle[rq.read_slot];
					o.read_source_index = list_origin[rq.read_slot];
				end else begin
					o.status = skl_pkg::ST_EMPTY;
				end
			end
			default: ;
		endcase
		o.stored_count = skl_pkg::COUNT_W'(list_count);
		return o;
	endfunction

	// Random request, biased toward keys and handles already in the list
	function automatic skl_pkg::req_t draw_list_request(input int ins_pct, input int rem_pct);
		skl_pkg::req_t r;
		int            p;
		r.req_type     = skl_pkg::REQ_READ;
		r.sort_key     = $urandom;
		r.item_handle  = $urandom;
		r.source_index = 16'($urandom);
		r.read_slot    = 4'($urandom_range(0, 15));
		p = $urandom_range(0, 99);
		if (p < ins_pct) begin
			r.req_type = skl_pkg::REQ_INSERT;
			case ($urandom_range(0, 9))
				0: r.sort_key = 32'h7FFF_FFFF;
				1: r.sort_key = 32'h8000_0000;
				2, 3: if (list_count > 0)
					r.sort_key = list_key[$urandom_range(0, list_count - 1)];
				4, 5: r.sort_key = (32'($urandom_range(0, 8)) - 32'd4) << 16;
				default: ;
			endcase
			if ($urandom_range(0, 3) == 0)
				r.item_handle = 32'($urandom_range(0, 7));
		end else if (p < ins_pct + rem_pct) begin
			r.req_type = skl_pkg::REQ_REMOVE;
			if (list_count > 0 && $urandom_range(0, 9) < 8)
				r.item_handle = list_handle[$urandom_range(0, list_count - 1)];
		end else if (p < 97) begin
			if (list_count > 0 && $urandom_range(0, 9) < 7)
				r.read_slot = 4'($urandom_range(0, list_count - 1));
		end else begin
			r.req_type = skl_pkg::REQ_NONE;
		end
		return r;
	endfunction

	task automatic add_row(input bit wr, input logic [skl_pkg::LIMIT_W-1:0] lim,
			input skl_pkg::req_kind_t kind,
			input logic [skl_pkg::KEY_W-1:0] key, input logic [skl_pkg::HANDLE_W-1:0] hnd,
			input logic [skl_pkg::ORIGIN_W-1:0] org, input logic [skl_pkg::SLOT_W-1:0] slot,
			input bit typed, input skl_pkg::status_kind_t st,
			input logic [skl_pkg::COUNT_W-1:0] cnt,
			input logic [skl_pkg::KEY_W-1:0] rk, input logic [skl_pkg::HANDLE_W-1:0] rh,
			input logic [skl_pkg::ORIGIN_W-1:0] ro);
		dir_row_t row;
		row.wr_limit             = wr;
		row.limit                = lim;
		row.rq.req_type          = kind;
		row.rq.sort_key          = key;
		row.rq.item_handle       = hnd;
		row.rq.source_index      = org;
		row.rq.read_slot         = slot;
		row.typed                = typed;
		row.want.status          = st;
		row.want.stored_count    = cnt;
		row.want.read_key        = rk;
		row.want.read_handle     = rh;
		row.want.read_source_index = ro;
		stim_table.push_back(row);
	endtask

	// Drive one request transaction; predict its result once it is taken
	task automatic send_req(input skl_pkg::req_t rq, input bit typed,
			input skl_pkg::rsp_t want);
		int            gap;
		skl_pkg::rsp_t pred;
		gap = steady_flow ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= rq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_list_result(rq);
		queued_responses.push_back(typed ? want : pred);
	endtask

	// Write the insert limit once the block has drained
	task automatic write_insert_limit(input logic [skl_pkg::LIMIT_W-1:0] v);
		in_valid <= 1'b0;
		while (queued_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		list_limit = int'(v);
	endtask

	// Result side: random stall before each transaction
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (queued_responses.size() == 0) begin
				$error("result with nothing outstanding: %p", out_data);
				mismatches++;
			end else begin
				want_rsp = queued_responses.pop_front();
				if (out_data.status !== want_rsp.status) begin
					$error("status: expected %0d, got %0d", want_rsp.status, out_data.status);
					mismatches++;
				end
				if (out_data.stored_count !== want_rsp.stored_count) begin
					$error("stored_count: expected %0d, got %0d",
						want_rsp.stored_count, out_data.stored_count);
					mismatches++;
				end
				if (out_data.read_key !== want_rsp.read_key) begin
					$error("read_key: expected %h, got %h", want_rsp.read_key, out_data.read_key);
					mismatches++;
				end
				if (out_data.read_handle !== want_rsp.read_handle) begin
					$error("read_handle: expected %h, got %h",
						want_rsp.read_handle, out_data.read_handle);
					mismatches++;
				end
				if (out_data.read_source_index !== want_rsp.read_source_index) begin
					$error("read_source_index: expected %h, got %h",
						want_rsp.read_source_index, out_data.read_source_index);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("Some tests failed");
		$finish;
	end

	// Main sequence
	initial begin
		int lim;
		int ph;
		int n;

		// Empty list: read, remove and the unused code
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 0, 1, skl_pkg::ST_EMPTY, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_REMOVE, 0, 0, 0, 0, 1, skl_pkg::ST_NOT_FOUND,
			0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_NONE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'hFFFF, 4'hF,
			1, skl_pkg::ST_OK, 0, 0, 0, 0);
		// Zero limit refuses inserts
		add_row(1, 5'd0, skl_pkg::REQ_INSERT, 32'h0001_0000, 32'h5, 16'h1, 0,
			1, skl_pkg::ST_FULL, 0, 0, 0, 0);
		// Limit above capacity; extreme keys and fields
		add_row(1, 5'd31, skl_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0,
			1, skl_pkg::ST_OK, 1, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_INSERT, 32'h8000_0000, 32'h0, 16'h0, 0,
			1, skl_pkg::ST_OK, 2, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd0,
			1, skl_pkg::ST_OK, 2, 32'h8000_0000, 32'h0, 16'h0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd1, 1, skl_pkg::ST_OK, 2,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		// Equal keys: newest goes first
		add_row(0, 0, skl_pkg::REQ_INSERT, 32'h0001_0000, 32'h11, 16'h1, 0,
			0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_INSERT, 32'h0001_0000, 32'h22, 16'h2, 0,
			0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd1, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd2, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		// Duplicate handle: remove takes the first match
		add_row(0, 0, skl_pkg::REQ_INSERT, 32'hFFFF_0000, 32'h22, 16'h3, 0,
			0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_REMOVE, 0, 32'h22, 0, 0, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd1, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		// Reads past the count
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd15, 1, skl_pkg::ST_EMPTY, 4, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd4, 1, skl_pkg::ST_EMPTY, 4, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_REMOVE, 0, 32'h1234_5678, 0, 0,
			1, skl_pkg::ST_NOT_FOUND, 4, 0, 0, 0);
		// Limit lowered below count: entries stay, inserts refused
		add_row(1, 5'd2, skl_pkg::REQ_INSERT, 32'h0, 32'h33, 16'h4, 0,
			1, skl_pkg::ST_FULL, 4, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_REMOVE, 0, 32'h0, 0, 0, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_READ, 0, 0, 0, 4'd0, 0, skl_pkg::ST_OK, 0, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_INSERT, 32'h0, 32'h44, 16'h5, 0,
			1, skl_pkg::ST_FULL, 3, 0, 0, 0);
		add_row(0, 0, skl_pkg::REQ_NONE, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 4'h0,
			1, skl_pkg::ST_OK, 3, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].wr_limit)
				write_insert_limit(stim_table[i].limit);
			send_req(stim_table[i].rq, stim_table[i].typed, stim_table[i].want);
		end

		// Random phases under different limits
		for (ph = 0; ph < PHASES; ph++) begin
			lim = (ph_limit[ph] > 31) ? $urandom_range(0, 31) : ph_limit[ph];
			write_insert_limit(skl_pkg::LIMIT_W'(lim));
			steady_flow = ph_steady[ph];
			for (n = 0; n < PHASE_ITEMS; n++)
				send_req(draw_list_request(ph_ins[ph], ph_rem[ph]), 1'b0, '0);
		end
		in_valid    <= 1'b0;
		steady_flow = 1'b0;

		while (queued_responses.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
